[rtl/sorted_priority_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_defines.svh
// Assertion macros shared by the queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// check a property while out of reset
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic               empty_flag;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } cmd_t;

endpackage

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: latch, execute, read back, strobe the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output spq_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    cmd_o.resp = 1'b0;
    done_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.resp = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

[rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell array with entry count, status and result register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::cmd_t cmd_i,
  input  spq_pkg::req_t req_i,
  output spq_pkg::rsp_t rsp_o
);
  import spq_pkg::*;

  req_t               req_q;
  logic signed [31:0] entries_q [DEPTH];
  logic signed [31:0] ins_d     [DEPTH];
  logic [DEPTH-1:0]   shift;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            status_q, status_d;
  rsp_t               rsp_q, rsp_d;
  logic               full, empty, do_push;
  logic [CNT_W-1:0]   cnt_m1;
  logic [31:0]        cnt_wide;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = (req_q.req_type == REQ_PUSH) && !full;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift[i] = (CNT_W'(i) < count_q) && (req_q.value < entries_q[i]);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if ((i > 0) && shift[(i > 0) ? i - 1 : 0]) begin
        ins_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else if (shift[i] || (CNT_W'(i) == count_q)) begin
        ins_d[i] = req_q.value;
      end else begin
        ins_d[i] = entries_q[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STS_OK;
    case (req_q.req_type)
      REQ_PUSH: begin
        if (full) status_d = STS_FULL;
        else      count_d  = count_q + CNT_W'(1);
      end
      REQ_POLL: begin
        if (empty) status_d = STS_EMPTY;
        else       count_d  = count_q - CNT_W'(1);
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign cnt_m1   = count_q - CNT_W'(1);
  assign cnt_wide = 32'(count_q);

  always_comb begin
    rsp_d.top_value   = empty ? 32'sd0 : entries_q[cnt_m1[IDX_W-1:0]];
    rsp_d.empty_flag  = empty;
    rsp_d.entry_count = cnt_wide[4:0];
    rsp_d.status      = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.exec) begin
      status_q <= status_d;
      if (do_push) entries_q <= ins_d;
    end
    if (cmd_i.resp) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// A request is latched at the accept edge, updates the sorted cell array in
// the execute state (a push compares against every cell at once and shifts
// the larger ones up) and reads the top entry into the result register in
// the response state. busy is high in the execute and response states;
// done_o pulses for one cycle, with rsp_o valid until the next readback;
// the receiver cannot hold it off, so it must sample rsp_o whenever
// done_o is high. A new request may be started in the same cycle as done_o.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req_i,
  output spq_pkg::rsp_t rsp_o,
  output logic          done_o
);
  import spq_pkg::*;

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  spq_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

[rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the queue's request and result timing, reset and result fields.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input spq_pkg::rsp_t rsp_i,
  input logic          done_i
);
  import spq_pkg::*;

  `SPQ_ASSERT(a_done_idle, clk_i, rst_ni, done_i |-> !busy, "result beat while busy")
  `SPQ_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##3 done_i, "result beat late")
  `SPQ_ASSERT(a_empty_cnt, clk_i, rst_ni,
              done_i |-> (rsp_i.empty_flag == (rsp_i.entry_count == 5'd0)),
              "empty flag disagrees with count")
  `SPQ_ASSERT(a_empty_top, clk_i, rst_ni,
              (done_i && rsp_i.empty_flag) |-> (rsp_i.top_value == 32'sd0),
              "non-zero top when empty")
  `SPQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!done_i && !busy),
                     "activity during reset")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .rsp_i  (rsp_o),
  .done_i (done_o)
);
